[hw/rtl/lzfd_pkg.sv]
`default_nettype none
package lzfd_pkg;

  // history window
  localparam int WINDOW_BYTES = 8192;
  localparam int WIN_AW       = $clog2(WINDOW_BYTES);
  // lane width, capped at eight by the data port
  localparam int LANE_BYTES   = 8;
  localparam int LANE_W       = 8 * LANE_BYTES;
  localparam int LANE_CW      = $clog2(LANE_BYTES + 1);

  localparam int CNT_W        = 17;
  localparam logic [CNT_W-1:0] MAX_OUT_RESET = 17'd16384;

  // command queue between front and back
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  // control byte classes
  localparam logic [7:0] LIT_CTRL_LIMIT = 8'd32;
  localparam logic [2:0] LEN_EXTRA_CODE = 3'd7;
  localparam logic [8:0] MATCH_BIAS     = 9'd3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LIMIT = 2'd1,
    ST_REF   = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_CTRL  = 2'd0,
    PH_LIT   = 2'd1,
    PH_EXTRA = 2'd2,
    PH_DIST  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_LIT  = 2'd1,
    CMD_COPY = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_RD    = 2'd1,
    BK_WR    = 2'd2,
    BK_FLUSH = 2'd3
  } back_st_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        lit;
    logic [WIN_AW:0]   distance;
    logic [8:0]        len;
    logic              last;
    status_t           status;
    logic [CNT_W-1:0]  total;
  } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/lzfd_if.sv]
`default_nettype none
interface lzfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface lzfd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_data;
  logic [3:0]  out_count;
  logic        run_last;
  logic        stream_end;
  logic [1:0]  status;
  logic [16:0] total_length;
  modport source (output valid, out_data, out_count, run_last, stream_end, status,
                  total_length, input ready);
  modport sink   (input valid, out_data, out_count, run_last, stream_end, status,
                  total_length, output ready);
endinterface
`default_nettype wire

[hw/rtl/lzfd_fifo.sv]
`default_nettype none
module lzfd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lzfd_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output lzfd_pkg::cmd_t     pop_cmd,
  output logic               empty
);
  import lzfd_pkg::*;

  cmd_t               slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   fill_r;

  assign full    = (fill_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (fill_r == '0);
  assign pop_cmd = slot_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_cmd;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) fill_r <= fill_r + 1'b1;
      else if (pop && !push) fill_r <= fill_r - 1'b1;
    end
  end

  ovf_chk: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push || pop)
    else $error("push into full queue");
  udf_chk: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("pop from empty queue");
  fill_chk: assert property (@(posedge clk) disable iff (!rst_n)
                             fill_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue fill out of range");
endmodule
`default_nettype wire

[hw/rtl/lzfd_front.sv]
`default_nettype none
module lzfd_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  lzfd_in_if.sink                        in_bus,
  input  wire logic [lzfd_pkg::CNT_W-1:0] max_out,
  output logic                           push,
  output lzfd_pkg::cmd_t                 push_cmd,
  input  wire logic                      full
);
  import lzfd_pkg::*;

  phase_t           ph_r, ph_nxt;
  logic [CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic [5:0]       lit_r, lit_nxt;
  logic [8:0]       mlen_r, mlen_nxt;
  logic [4:0]       ohi_r, ohi_nxt;
  status_t          err_r, err_nxt;
  cmd_kind_t        kind;
  logic             accept;
  logic [7:0]       b;
  logic [WIN_AW:0]  distance;
  logic [8:0]       len;
  logic [CNT_W:0]   need;

  assign in_bus.ready = !full;
  assign accept       = in_bus.valid && !full;
  assign b            = in_bus.in_byte;
  assign distance     = {ohi_r, b} + 1'b1;
  assign len          = mlen_r + MATCH_BIAS;

  // token parser
  always_comb begin
    ph_nxt   = ph_r;
    ocnt_nxt = ocnt_r;
    lit_nxt  = lit_r;
    mlen_nxt = mlen_r;
    ohi_nxt  = ohi_r;
    err_nxt  = err_r;
    kind     = CMD_NONE;
    need     = '0;
    if (err_r == ST_OK) begin
      unique case (ph_r)
        PH_CTRL: begin
          if (b < LIT_CTRL_LIMIT) begin
            need = {1'b0, ocnt_r} + (CNT_W+1)'(b) + 1'b1;
            if (need > {1'b0, max_out}) err_nxt = ST_LIMIT;
            else begin
              lit_nxt = {1'b0, b[4:0]} + 1'b1;
              ph_nxt  = PH_LIT;
            end
          end else begin
            mlen_nxt = {6'd0, b[7:5]} - 1'b1;
            ohi_nxt  = b[4:0];
            ph_nxt   = (b[7:5] == LEN_EXTRA_CODE) ? PH_EXTRA : PH_DIST;
          end
        end
        PH_LIT: begin
          kind     = CMD_LIT;
          ocnt_nxt = ocnt_r + 1'b1;
          lit_nxt  = lit_r - 1'b1;
          if (lit_nxt == '0) ph_nxt = PH_CTRL;
        end
        PH_EXTRA: begin
          mlen_nxt = mlen_r + 9'(b);
          ph_nxt   = PH_DIST;
        end
        PH_DIST: begin
          need = {1'b0, ocnt_r} + (CNT_W+1)'(len);
          if (need > {1'b0, max_out}) err_nxt = ST_LIMIT;
          else if ((CNT_W)'(distance) > ocnt_r) err_nxt = ST_REF;
          else begin
            kind     = CMD_COPY;
            ocnt_nxt = need[CNT_W-1:0];
          end
          ph_nxt = PH_CTRL;
        end
        default: ph_nxt = PH_CTRL;
      endcase
    end
    if (in_bus.in_last && err_nxt == ST_OK && ph_nxt != PH_CTRL) err_nxt = ST_TRUNC;
  end

  // command to the back end
  assign push = accept && (kind != CMD_NONE || in_bus.in_last);
  always_comb begin
    push_cmd.kind     = kind;
    push_cmd.lit      = b;
    push_cmd.distance = distance;
    push_cmd.len      = len;
    push_cmd.last     = in_bus.in_last;
    push_cmd.status   = in_bus.in_last ? err_nxt : ST_OK;
    push_cmd.total    = (in_bus.in_last && err_nxt == ST_OK) ? ocnt_nxt : '0;
  end

  // stream state, cleared after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_bus.in_last)) begin
      ph_r   <= PH_CTRL;
      ocnt_r <= '0;
      lit_r  <= '0;
      mlen_r <= '0;
      ohi_r  <= '0;
      err_r  <= ST_OK;
    end else if (accept) begin
      ph_r   <= ph_nxt;
      ocnt_r <= ocnt_nxt;
      lit_r  <= lit_nxt;
      mlen_r <= mlen_nxt;
      ohi_r  <= ohi_nxt;
      err_r  <= err_nxt;
    end
  end

  err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
      (err_r != ST_OK && !(accept && in_bus.in_last)) |=> err_r == $past(err_r))
    else $error("error code changed before stream end");
  no_out_err: assert property (@(posedge clk) disable iff (!rst_n)
      (err_r != ST_OK) |-> kind == CMD_NONE)
    else $error("output command after error");
  cnt_lim: assert property (@(posedge clk) disable iff (!rst_n)
      (push && kind == CMD_COPY) |-> ocnt_nxt <= max_out)
    else $error("copy beyond output limit");
endmodule
`default_nettype wire

[hw/rtl/lzfd_back.sv]
`default_nettype none
module lzfd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire lzfd_pkg::cmd_t pop_cmd,
  input  wire logic           empty,
  output logic                pop,
  lzfd_out_if.source          out_bus
);
  import lzfd_pkg::*;

  logic [7:0]        hist_mem [WINDOW_BYTES];
  logic [7:0]        rdata_r;
  logic [WIN_AW-1:0] rd_addr;
  logic              we;
  logic [7:0]        wdata;

  back_st_t          st_r, st_nxt;
  cmd_t              cur_r, cur_nxt;
  logic [WIN_AW-1:0] wp_r, wp_nxt;
  logic [8:0]        rem_r, rem_nxt;
  logic              fin_r, fin_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic [LANE_CW-1:0] lcnt_r, lcnt_nxt;

  logic              ov_r, ov_nxt;
  logic [63:0]       od_r, od_nxt;
  logic [3:0]        oc_r, oc_nxt;
  logic              orl_r, orl_nxt, ose_r, ose_nxt;
  status_t           ost_r, ost_nxt;
  logic [CNT_W-1:0]  otl_r, otl_nxt;

  assign rd_addr = wp_r - cur_r.distance[WIN_AW-1:0];

  // history window
  always_ff @(posedge clk) begin
    if (we) hist_mem[wp_r] <= wdata;
    rdata_r <= hist_mem[rd_addr];
  end

  // copy sequencer and lane packer
  always_comb begin
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    wp_nxt   = wp_r;
    rem_nxt  = rem_r;
    fin_nxt  = fin_r;
    lane_nxt = lane_r;
    lcnt_nxt = lcnt_r;
    pop      = 1'b0;
    we       = 1'b0;
    wdata    = rdata_r;
    ov_nxt   = ov_r && !out_bus.ready;
    od_nxt   = od_r;
    oc_nxt   = oc_r;
    orl_nxt  = orl_r;
    ose_nxt  = ose_r;
    ost_nxt  = ost_r;
    otl_nxt  = otl_r;
    unique case (st_r)
      BK_IDLE: begin
        if (!empty) begin
          pop     = 1'b1;
          cur_nxt = pop_cmd;
          unique case (pop_cmd.kind)
            CMD_LIT: begin
              we       = 1'b1;
              wdata    = pop_cmd.lit;
              wp_nxt   = wp_r + 1'b1;
              lane_nxt = LANE_W'(pop_cmd.lit);
              lcnt_nxt = LANE_CW'(1);
              fin_nxt  = 1'b1;
              st_nxt   = BK_FLUSH;
            end
            CMD_COPY: begin
              rem_nxt = pop_cmd.len;
              st_nxt  = BK_RD;
            end
            default: begin
              fin_nxt = 1'b1;
              st_nxt  = BK_FLUSH;
            end
          endcase
        end
      end
      BK_RD: st_nxt = BK_WR;
      BK_WR: begin
        we       = 1'b1;
        wp_nxt   = wp_r + 1'b1;
        lane_nxt[8*lcnt_r[LANE_CW-2:0] +: 8] = rdata_r;
        lcnt_nxt = lcnt_r + 1'b1;
        rem_nxt  = rem_r - 1'b1;
        if (rem_r == 9'd1) begin
          fin_nxt = 1'b1;
          st_nxt  = BK_FLUSH;
        end else if (lcnt_nxt == LANE_CW'(LANE_BYTES)) begin
          fin_nxt = 1'b0;
          st_nxt  = BK_FLUSH;
        end else st_nxt = BK_RD;
      end
      BK_FLUSH: begin
        if (!ov_r || out_bus.ready) begin
          ov_nxt   = 1'b1;
          od_nxt   = lane_r;
          oc_nxt   = 4'(lcnt_r);
          orl_nxt  = fin_r;
          ose_nxt  = fin_r && cur_r.last;
          ost_nxt  = (fin_r && cur_r.last) ? cur_r.status : ST_OK;
          otl_nxt  = (fin_r && cur_r.last) ? cur_r.total : '0;
          lane_nxt = '0;
          lcnt_nxt = '0;
          if (fin_r) begin
            st_nxt = BK_IDLE;
            if (cur_r.last) wp_nxt = '0;
          end else st_nxt = BK_RD;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      wp_r   <= '0;
      lane_r <= '0;
      lcnt_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      wp_r   <= wp_nxt;
      lane_r <= lane_nxt;
      lcnt_r <= lcnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    rem_r <= rem_nxt;
    fin_r <= fin_nxt;
    od_r  <= od_nxt;
    oc_r  <= oc_nxt;
    orl_r <= orl_nxt;
    ose_r <= ose_nxt;
    ost_r <= ost_nxt;
    otl_r <= otl_nxt;
  end

  assign out_bus.valid        = ov_r;
  assign out_bus.out_data     = od_r;
  assign out_bus.out_count    = oc_r;
  assign out_bus.run_last     = orl_r;
  assign out_bus.stream_end   = ose_r;
  assign out_bus.status       = ost_r;
  assign out_bus.total_length = otl_r;

  lane_room: assert property (@(posedge clk) disable iff (!rst_n)
      st_r == BK_WR |-> lcnt_r < LANE_CW'(LANE_BYTES))
    else $error("lane overflow");
  end_run: assert property (@(posedge clk) disable iff (!rst_n)
      ov_r && ose_r |-> orl_r)
    else $error("stream end off a run end");
  stat_end: assert property (@(posedge clk) disable iff (!rst_n)
      ov_r && (ost_r != ST_OK || otl_r != '0) |-> ose_r)
    else $error("status or length before stream end");
endmodule
`default_nettype wire

[hw/rtl/lzf_decompressor.sv]
`default_nettype none
// LZF stream decompressor. Compressed bytes enter on in_bus; the front parser
// takes one per cycle while its four-entry command queue has room, and
// decompressed data leaves on out_bus in lanes of up to eight bytes. Control
// and extra length bytes end in the parser and queue nothing, except the final
// byte, which always queues one command. In the back end a literal byte takes
// the flush state as its own lane beat after the idle state pops it, so the
// back end paces a long literal run. A back reference takes a history read
// state and a history write state per byte, through the single 8 KiB window
// RAM, and the flush state per lane. A stalled out_bus holds the back end
// once its output register is full. The user must write max_out through
// cfg_we/cfg_data only while idle; the block itself does not enforce it.
module lzf_decompressor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lzfd_in_if.sink          in_bus,
  lzfd_out_if.source       out_bus,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_data
);
  import lzfd_pkg::*;

  logic [CNT_W-1:0] max_out_r;
  logic             push, pop, full, empty;
  cmd_t             push_cmd, pop_cmd;

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) max_out_r <= MAX_OUT_RESET;
    else if (cfg_we) max_out_r <= cfg_data;
  end

  lzfd_front u_front (
    .clk, .rst_n, .in_bus, .max_out(max_out_r), .push, .push_cmd, .full
  );

  lzfd_fifo u_fifo (
    .clk, .rst_n, .push, .push_cmd, .full, .pop, .pop_cmd, .empty
  );

  lzfd_back u_back (
    .clk, .rst_n, .pop_cmd, .empty, .pop, .out_bus
  );
endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import lzfd_pkg::*;

  // lane beat as predicted
  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        run_last;
    logic        stream_end;
    status_t     status;
    logic [16:0] total;
  } lane_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [16:0] cfg_data;

  lzfd_in_if  in_if ();
  lzfd_out_if out_if ();

  lzf_decompressor uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // decoder state mirror
  logic [7:0]  win_mem [WINDOW_BYTES];
  logic [16:0] produced;
  phase_t      phase;
  logic [5:0]  lit_left;
  logic [8:0]  copy_len;
  logic [4:0]  dist_hi;
  status_t     err;
  logic [16:0] limit_bytes;

  lane_t       lane_q[$];
  logic [7:0]  stim[$];
  int          fail_cnt = 0;
  int          idle_cycles = 0;
  bit          no_gaps;
  int          out_stall = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // random gap length: mostly zero or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic clear_stream();
    produced = '0;
    phase    = PH_CTRL;
    lit_left = '0;
    copy_len = '0;
    dist_hi  = '0;
    err      = ST_OK;
  endtask

  // decode one accepted byte and queue its lane beats
  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [7:0]  outb[$];
    logic [13:0] distance;
    logic [16:0] n;
    int          lanes;
    int          k;
    int          j;
    lane_t       ln;
    outb.delete();
    if (err == ST_OK) begin
      case (phase)
        PH_CTRL: begin
          if (b < LIT_CTRL_LIMIT) begin
            if (produced + b + 1 > limit_bytes) err = ST_LIMIT;
            else begin
              lit_left = 6'(b + 1);
              phase = PH_LIT;
            end
          end else begin
            copy_len = 9'(b[7:5] - 1);
            dist_hi  = b[4:0];
            phase = (b[7:5] == LEN_EXTRA_CODE) ? PH_EXTRA : PH_DIST;
          end
        end
        PH_LIT: begin
          win_mem[produced[WIN_AW-1:0]] = b;
          produced = produced + 17'd1;
          outb = {outb, b};
          lit_left = lit_left - 6'd1;
          if (lit_left == 0) phase = PH_CTRL;
        end
        PH_EXTRA: begin
          copy_len = copy_len + 9'(b);
          phase = PH_DIST;
        end
        default: begin
          distance = {1'b0, dist_hi, b} + 14'd1;
          n = 17'(copy_len + MATCH_BIAS);
          if (produced + n > limit_bytes) err = ST_LIMIT;
          else if (distance > produced) err = ST_REF;
          else begin
            for (j = 0; j < n; j++) begin
              win_mem[produced[WIN_AW-1:0]] = win_mem[WIN_AW'(produced - distance)];
              outb = {outb, win_mem[produced[WIN_AW-1:0]]};
              produced = produced + 17'd1;
            end
          end
          phase = PH_CTRL;
        end
      endcase
    end
    if (last && err == ST_OK && phase != PH_CTRL) err = ST_TRUNC;
    lanes = (outb.size() + 7) / 8;
    if (lanes == 0 && last) lanes = 1;
    for (k = 0; k < lanes; k++) begin
      ln.data  = '0;
      ln.count = '0;
      for (j = 0; j < 8 && k * 8 + j < outb.size(); j++) begin
        ln.data[8*j +: 8] = outb[k*8 + j];
        ln.count = ln.count + 4'd1;
      end
      ln.run_last   = (k == lanes - 1);
      ln.stream_end = ln.run_last && last;
      ln.status     = ln.stream_end ? err : ST_OK;
      ln.total      = (ln.stream_end && err == ST_OK) ? produced : '0;
      lane_q = {lane_q, ln};
    end
    if (last) clear_stream();
  endtask

  // send one byte; valid stays high when the next byte follows at once
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    decode_byte(b, last);
  endtask

  // send the staged bytes as one stream, last flag on the final byte when mark_last is set
  task automatic send_stim(input bit mark_last);
    int i;
    for (i = 0; i < stim.size(); i++)
      send_byte(stim[i], mark_last && (i == stim.size() - 1));
    stim.delete();
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (lane_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_limit(input logic [16:0] v);
    wait_drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    limit_bytes = v;
  endtask

  // append one byte to the staged stream
  task automatic stage_byte(input logic [7:0] v);
    stim = {stim, v};
  endtask

  task automatic add_literal(input int n);
    int i;
    stage_byte(8'(n - 1));
    for (i = 0; i < n; i++) stage_byte(8'($urandom_range(0, 255)));
  endtask

  // back reference of len bytes (3..264) at the given distance (1..8192)
  task automatic add_copy(input int len, input int distance);
    logic [12:0] d;
    d = 13'(distance - 1);
    if (len - 2 >= 7) begin
      stage_byte({LEN_EXTRA_CODE, d[12:8]});
      stage_byte(8'(len - 9));
    end else
      stage_byte({3'(len - 2), d[12:8]});
    stage_byte(d[7:0]);
  endtask

  // literals, copies, overlap and the longest match and farthest distance
  task automatic test_tokens();
    int i;
    set_limit(17'h10000);
    stage_byte(8'h00); stage_byte(8'h00);
    add_literal(8);
    stim[stim.size()-1] = 8'hff;
    add_copy(3, 1);
    add_copy(8, 9);
    add_copy(264, 2);
    send_stim(1'b1);
    // fill more than the whole window, then reach back its full size
    no_gaps = 1;
    add_literal(8);
    for (i = 0; i < 31; i++) add_copy(264, 8);
    add_literal(8);
    add_copy(9, 8192);
    send_stim(1'b1);
    no_gaps = 0;
  endtask

  // limit, reference before start, truncation, bytes after an error
  task automatic test_errors();
    set_limit(17'd1);
    add_literal(1);
    send_stim(1'b1);
    add_literal(1);
    add_literal(2);
    stage_byte(8'h5a);
    send_stim(1'b1);
    set_limit(17'd16384);
    add_literal(4);
    add_copy(3, 5);
    add_literal(1);
    send_stim(1'b1);
    stage_byte(8'h03);
    send_stim(1'b1);
    stage_byte(8'hE0);
    send_stim(1'b1);
    add_literal(2);
    stage_byte(8'h40);
    send_stim(1'b1);
    add_literal(3);
    stim.delete(stim.size() - 1);
    send_stim(1'b1);
    set_limit(17'd12);
    add_literal(8);
    add_copy(5, 8);
    send_stim(1'b1);
  endtask

  // random streams, mostly well formed
  task automatic test_random();
    int sent;
    int ntok;
    int t;
    int made;
    int len;
    bit drained;
    sent = 0;
    drained = 0;
    while (sent < 20) begin
      case ($urandom_range(0, 3))
        0: set_limit(17'($urandom_range(1, 65536)));
        1: set_limit(17'($urandom_range(10, 200)));
        default: ;
      endcase
      ntok = $urandom_range(1, 6);
      made = 0;
      for (t = 0; t < ntok; t++) begin
        if ($urandom_range(0, 9) == 0) begin
          stage_byte(8'($urandom_range(0, 255)));
          stage_byte(8'($urandom_range(0, 255)));
        end else if (made == 0 || $urandom_range(0, 1) == 0) begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 6);
          add_literal(len);
          made += len;
        end else begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 264) : $urandom_range(3, 8);
          add_copy(len, $urandom_range(1, (made > 8192) ? 8192 : made + 1));
          made += len;
        end
      end
      if ($urandom_range(0, 9) == 0) stim.delete(stim.size() - 1);
      sent += stim.size();
      send_stim(1'b1);
      // hold off until every lane has arrived, once mid-run
      if (!drained) begin
        wait_drain();
        drained = 1;
      end
    end
  endtask

  // result side ready with random stalls
  always @(negedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else if (out_stall > 0) begin
      out_if.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (no_gaps || $urandom_range(0, 3) != 0) out_if.ready <= 1'b1;
    else begin
      out_if.ready <= 1'b0;
      out_stall <= pick_gap();
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    lane_t ex;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (lane_q.size() == 0) begin
        $display("%0t unexpected beat data %h count %0d", $time, out_if.out_data,
                 out_if.out_count);
        fail_cnt++;
      end else begin
        ex = lane_q.pop_front();
        if (out_if.out_data !== ex.data) begin
          $display("%0t out_data exp %h got %h", $time, ex.data, out_if.out_data);
          fail_cnt++;
        end
        if (out_if.out_count !== ex.count) begin
          $display("%0t out_count exp %0d got %0d", $time, ex.count, out_if.out_count);
          fail_cnt++;
        end
        if (out_if.run_last !== ex.run_last) begin
          $display("%0t run_last exp %b got %b", $time, ex.run_last, out_if.run_last);
          fail_cnt++;
        end
        if (out_if.stream_end !== ex.stream_end) begin
          $display("%0t stream_end exp %b got %b", $time, ex.stream_end, out_if.stream_end);
          fail_cnt++;
        end
        if (out_if.status !== ex.status) begin
          $display("%0t status exp %0d got %0d", $time, ex.status, out_if.status);
          fail_cnt++;
        end
        if (out_if.total_length !== ex.total) begin
          $display("%0t total_length exp %0d got %0d", $time, ex.total,
                   out_if.total_length);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 30000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    in_if.in_last = 1'b0;
    no_gaps       = 0;
    limit_bytes   = MAX_OUT_RESET;
    clear_stream();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_tokens();
    test_errors();
    test_random();
    wait_drain();
    if (fail_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

[lzf_decompressor.f]
hw/rtl/lzfd_pkg.sv
hw/rtl/lzfd_if.sv
hw/rtl/lzfd_fifo.sv
hw/rtl/lzfd_front.sv
hw/rtl/lzfd_back.sv
hw/rtl/lzf_decompressor.sv
sim/testbench.sv
